### design/ctrg_pkg.sv
`timescale 1ns / 1ps
package ctrg_pkg;

    localparam int MaxChunk  = 64;
    localparam int PhaseBits = 32;

    localparam logic [2:0] REG_GEN_KIND      = 3'd0;
    localparam logic [2:0] REG_TONE_FREQ     = 3'd1;
    localparam logic [2:0] REG_SAMPLE_RATE   = 3'd2;
    localparam logic [2:0] REG_STREAM_LENGTH = 3'd3;
    localparam logic [2:0] REG_CHUNK_LENGTH  = 3'd4;
    localparam logic [2:0] REG_RAMP_START    = 3'd5;
    localparam logic [2:0] REG_RAMP_SLOPE    = 3'd6;

    localparam logic [31:0] Q30One = 32'd1073741824;
    localparam logic [31:0] SinC1  = 32'd1686629713;
    localparam logic [31:0] SinC3  = 32'd693598671;
    localparam logic [31:0] SinC5  = 32'd85569306;
    localparam logic [31:0] SinC7  = 32'd5026990;
    localparam logic [31:0] SinC9  = 32'd172272;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_X2,
        ST_HORNER,
        ST_FINAL,
        ST_RAMP,
        ST_EMIT,
        ST_ENDED
    } t_state;

endpackage

### design/chunked_tone_and_ramp_generator_top.sv
`timescale 1ns / 1ps
// Chunked tone / ramp generator.
// Config: write i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready is
// always high. Write only while idle.
// Request channel: i_in_valid/o_in_stall with i_restart. Each transfer
// asks for the next chunk: min(chunk_length, 64, samples left) results
// (a chunk_length of 0 counts as 1), last_of_chunk on the final one; an
// exhausted stream gives one result with stream_ended set and sample 0.
// Result channel: o_out_valid/i_out_stall with sample, last, ended.
// Sequence: a restart adds a bit-serial divide for the phase step.
// Ramp samples come from the ramp state alone; tone samples use one shared
// 32x32 multiplier (x^2, four Horner products, one final product). Each
// sample then passes an emit state that waits while the receiver stalls.
// o_in_stall stays high until the request's last result is taken.
// Reset: synchronous, active low; registers return to their defaults and
// position, phase, step and ramp value clear to zero.
module chunked_tone_and_ramp_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_sample_value,
    output logic        o_last_of_chunk,
    output logic        o_stream_ended
);
    import ctrg_pkg::*;

    logic        r_kind;
    logic [16:0] r_freq;
    logic [17:0] r_rate;
    logic [31:0] r_slen;
    logic [6:0]  r_clen;
    logic [31:0] r_rstart, r_rslope;

    logic [31:0] r_pos, n_pos;
    logic [PhaseBits-1:0] r_phase, n_phase, r_step, n_step;
    logic [31:0] r_ramp, n_ramp;
    logic [6:0]  r_left, n_left;
    logic [31:0] r_x, n_x, r_x2, n_x2, r_p, n_p;
    logic [1:0]  r_quad, n_quad;
    logic [2:0]  r_hi, n_hi;
    logic        r_wait, n_wait;
    logic [31:0] r_out, n_out;
    t_state r_st, n_st;

    logic        w_div_start, w_div_done;
    logic [PhaseBits-1:0] w_quot;
    logic [31:0] w_ma, w_mb, w_mp;
    logic [31:0] w_p32, w_frac, w_avail;
    logic [31:0] w_x;
    logic [6:0]  w_n;
    logic [32:0] w_rsum;
    logic [31:0] w_rsat, w_s;
    logic [31:0] w_coef;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0; r_freq <= 17'd1000; r_rate <= 18'd48000;
            r_slen <= '0; r_clen <= 7'd64; r_rstart <= '0; r_rslope <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GEN_KIND:      r_kind   <= i_cfg_data[0];
                REG_TONE_FREQ:     r_freq   <= i_cfg_data[16:0];
                REG_SAMPLE_RATE:   r_rate   <= i_cfg_data[17:0];
                REG_STREAM_LENGTH: r_slen   <= i_cfg_data;
                REG_CHUNK_LENGTH:  r_clen   <= i_cfg_data[6:0];
                REG_RAMP_START:    r_rstart <= i_cfg_data;
                REG_RAMP_SLOPE:    r_rslope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ctrg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_freq(r_freq), .i_rate(r_rate), .o_done(w_div_done), .o_quot(w_quot)
    );

    ctrg_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    assign w_p32  = 32'(r_phase) << (32 - PhaseBits);
    assign w_frac = {2'b00, w_p32[29:0]};
    assign w_x    = w_p32[30] ? (Q30One - w_frac) : w_frac;
    assign w_avail = r_slen - r_pos;
    always_comb begin
        w_n = (r_clen == 7'd0) ? 7'd1 : r_clen;
        if (w_n > 7'(MaxChunk)) w_n = 7'(MaxChunk);
        if (w_avail < 32'(w_n)) w_n = w_avail[6:0];
    end
    assign w_rsum = {r_ramp[31], r_ramp} + {r_rslope[31], r_rslope};
    assign w_rsat = (w_rsum[32] != w_rsum[31]) ?
                    (w_rsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : w_rsum[31:0];
    always_comb begin
        case (r_hi)
            3'd0: w_coef = SinC7;
            3'd1: w_coef = SinC5;
            3'd2: w_coef = SinC3;
            default: w_coef = SinC1;
        endcase
    end
    assign w_s = (w_mp + 32'd8192) >> 14;

    // multiplier operand select
    always_comb begin
        w_ma = r_x;
        w_mb = r_x;
        case (r_st)
            ST_X2:     begin w_ma = w_x;  w_mb = w_x; end
            ST_HORNER: begin w_ma = r_x2; w_mb = r_p; end
            ST_FINAL:  begin w_ma = r_x;  w_mb = r_p; end
            default:   ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:   if (i_in_valid) n_st = i_restart ? ST_DIV : ST_CHECK;
            ST_DIV:    if (w_div_done) n_st = ST_CHECK;
            ST_CHECK:  n_st = (r_pos >= r_slen) ? ST_ENDED : (r_kind ? ST_RAMP : ST_X2);
            ST_X2:     if (r_wait) n_st = ST_HORNER;
            ST_HORNER: if (r_wait && r_hi == 3'd3) n_st = ST_FINAL;
            ST_FINAL:  if (r_wait) n_st = ST_EMIT;
            ST_RAMP:   n_st = ST_EMIT;
            ST_EMIT:   if (!i_out_stall) begin
                if (r_left == 7'd1) n_st = ST_IDLE;
                else n_st = r_kind ? ST_RAMP : ST_X2;
            end
            ST_ENDED:  if (!i_out_stall) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pos = r_pos; n_phase = r_phase; n_step = r_step; n_ramp = r_ramp;
        n_left = r_left; n_x = r_x; n_x2 = r_x2; n_p = r_p; n_quad = r_quad;
        n_hi = r_hi; n_wait = 1'b0; n_out = r_out;
        w_div_start = 1'b0;
        case (r_st)
            ST_IDLE: if (i_in_valid && i_restart) begin
                n_pos = '0; n_phase = '0; n_ramp = r_rstart;
                w_div_start = 1'b1;
            end
            ST_DIV: if (w_div_done) n_step = w_quot;
            ST_CHECK: begin
                n_left = w_n;
                if (r_pos < r_slen) n_pos = r_pos + 32'(w_n);
            end
            ST_X2: begin
                if (!r_wait) begin
                    n_quad = w_p32[31:30];
                    n_x = w_x;
                end
                n_wait = !r_wait;
                if (r_wait) begin n_x2 = w_mp; n_p = SinC9; n_hi = 3'd0; end
            end
            ST_HORNER: begin
                n_wait = !r_wait;
                if (r_wait) begin
                    n_p = w_coef - w_mp;
                    n_hi = r_hi + 3'd1;
                end
            end
            ST_FINAL: begin
                n_wait = !r_wait;
                if (r_wait) begin
                    n_out = (w_s > 32'd65536) ? 32'd65536 : w_s;
                    if (r_quad[1]) n_out = -n_out;
                    n_phase = r_phase + r_step;
                end
            end
            ST_RAMP: begin
                n_out = r_ramp;
                n_ramp = w_rsat;
            end
            ST_EMIT: if (!i_out_stall) n_left = r_left - 7'd1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left; r_x <= n_x; r_x2 <= n_x2; r_p <= n_p;
        r_quad <= n_quad; r_hi <= n_hi; r_out <= n_out;
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_pos <= '0; r_phase <= '0; r_step <= '0;
            r_ramp <= '0; r_wait <= 1'b0;
        end else begin
            r_st <= n_st; r_pos <= n_pos; r_phase <= n_phase; r_step <= n_step;
            r_ramp <= n_ramp; r_wait <= n_wait;
        end
    end

    assign o_in_stall      = (r_st != ST_IDLE);
    assign o_out_valid     = (r_st == ST_EMIT) || (r_st == ST_ENDED);
    assign o_sample_value  = (r_st == ST_ENDED) ? 32'sd0 : r_out;
    assign o_last_of_chunk = (r_st == ST_ENDED) || (r_left == 7'd1);
    assign o_stream_ended  = (r_st == ST_ENDED);
endmodule

### design/ctrg_div.sv
`timescale 1ns / 1ps
module ctrg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_freq,
    input  logic [17:0] i_rate,
    output logic        o_done,
    output logic [ctrg_pkg::PhaseBits-1:0] o_quot
);
    import ctrg_pkg::*;

    localparam int NumW = 17 + PhaseBits;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] r_num, n_num;
    logic [PhaseBits-1:0] r_quot, n_quot;
    logic [18:0] r_rem, n_rem;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic r_done, n_done;
    logic [18:0] w_trial;

    always_comb begin
        n_num  = r_num;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[17:0], r_num[NumW-1]};
        if (i_start) begin
            n_num  = {i_freq, {PhaseBits{1'b0}}};
            n_rem  = '0;
            n_quot = '0;
            n_cnt  = CntW'(NumW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NumW-2:0], 1'b0};
            if (i_rate != 18'd0 && w_trial >= {1'b0, i_rate}) begin
                n_rem  = w_trial - {1'b0, i_rate};
                n_quot = {r_quot[PhaseBits-2:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[PhaseBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (i_rate == 18'd0) n_quot = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### design/ctrg_mul.sv
`timescale 1ns / 1ps
module ctrg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    logic [63:0] w_prod;
    logic [31:0] r_p;

    assign w_prod = {32'd0, i_a} * {32'd0, i_b};

    always_ff @(posedge i_clk) begin
        r_p <= w_prod[61:30];
    end

    assign o_p = r_p;
endmodule
